// ===== src/rsbl_pkg.sv =====
package rsbl_pkg;

  localparam int CORDIC_STEPS = 28;
  localparam int XY_W = 36;
  localparam int ANG_W = 32;
  localparam int NUM_W = 29;
  localparam int MAG_W = 28;
  localparam int PITCH_W = 20;
  localparam int CNT_W = 7;
  localparam int COORD_W = 24;
  localparam int IDX_W = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [ANG_W-1:0] TURN_ZERO = 32'h0000_0000;
  localparam logic [ANG_W-1:0] TURN_QUARTER = 32'h4000_0000;
  localparam logic [ANG_W-1:0] TURN_HALF = 32'h8000_0000;
  localparam logic [ANG_W-1:0] TURN_3QUARTER = 32'hC000_0000;

  localparam logic [PITCH_W-1:0] RESET_PITCH = 20'd8192;
  localparam logic [CNT_W-1:0] RESET_RINGS = 7'd4;
  localparam logic [CNT_W-1:0] RESET_BLOCKS = 7'd32;

  localparam logic [IDX_W:0] INDEX_LIMIT = 13'd4095;

  // atan(2^-i) in Q0.32 turns.
  localparam logic [ANG_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RING_PITCH = 2'd0,
    REG_RING_COUNT = 2'd1,
    REG_BLOCKS_PER_RING = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [PITCH_W-1:0] ring_pitch;
    logic [CNT_W-1:0] ring_count;
    logic [CNT_W-1:0] blocks_per_ring;
  } cfg_t;

  typedef struct packed {
    logic direct;
    logic [ANG_W-1:0] ang;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [MAG_W-1:0] mag;
    logic neg;
    logic bad;
  } task_t;

endpackage

// ===== src/rsbl_front.sv =====
module rsbl_front #(
  parameter int MAX_RINGS = 64,
  parameter int MAX_BLOCKS_PER_RING = 64
) (
  input  logic signed [23:0] x_coord,
  input  logic signed [23:0] y_coord,
  input  logic signed [23:0] z_coord,
  input  rsbl_pkg::cfg_t     cfg,
  output rsbl_pkg::task_t    item
);
  import rsbl_pkg::*;

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic [26:0] prod;
  logic signed [NUM_W-1:0] num;

  assign xs = {{4{x_coord[23]}}, x_coord, 8'h00};
  assign ys = {{4{y_coord[23]}}, y_coord, 8'h00};
  assign prod = 27'(cfg.ring_pitch) * 27'(cfg.ring_count);
  assign num = {{4{z_coord[23]}}, z_coord, 1'b0} + $signed({2'b00, prod});

  always_comb begin
    item.mag = num[NUM_W-1] ? MAG_W'(-num) : num[MAG_W-1:0];
    item.neg = num[NUM_W-1];
    item.bad = (cfg.ring_pitch == '0) || (cfg.blocks_per_ring == '0) ||
               (int'(cfg.ring_count) > MAX_RINGS) ||
               (int'(cfg.blocks_per_ring) > MAX_BLOCKS_PER_RING);
    item.direct = 1'b0;
    item.x = xs;
    item.y = ys;
    item.ang = TURN_ZERO;
    priority if (y_coord == '0) begin
      item.direct = 1'b1;
      item.ang = x_coord[23] ? TURN_HALF : TURN_ZERO;
    end else if (x_coord == '0) begin
      item.direct = 1'b1;
      item.ang = y_coord[23] ? TURN_3QUARTER : TURN_QUARTER;
    end else if (x_coord[23]) begin
      item.x = -xs;
      item.y = -ys;
      item.ang = TURN_HALF;
    end else begin
      item.ang = TURN_ZERO;
    end
  end

endmodule

// ===== src/rsbl_queue.sv =====
module rsbl_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rsbl_pkg::task_t push_item,
  input  logic            pop,
  output logic            out_valid,
  output rsbl_pkg::task_t out_item,
  output logic            full
);
  import rsbl_pkg::*;

  task_t mem [QUEUE_DEPTH];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic do_pop;

  assign out_valid = (count != 2'd0);
  assign full = (count == 2'(QUEUE_DEPTH));
  assign out_item = mem[rd_ptr];
  assign do_pop = pop && out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== src/rsbl_cordic.sv =====
module rsbl_cordic (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  rsbl_pkg::task_t item,
  output logic            out_valid,
  output logic [31:0]     ang
);
  import rsbl_pkg::*;

  logic signed [XY_W-1:0] sx [CORDIC_STEPS];
  logic signed [XY_W-1:0] sy [CORDIC_STEPS];
  logic [ANG_W-1:0] sa [CORDIC_STEPS];
  logic sd [CORDIC_STEPS];
  logic sv [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    logic signed [XY_W-1:0] xi;
    logic signed [XY_W-1:0] yi;
    logic [ANG_W-1:0] ai;
    logic di;
    logic vi;
    if (i == 0) begin : g_first
      assign xi = item.x;
      assign yi = item.y;
      assign ai = item.ang;
      assign di = item.direct;
      assign vi = in_valid;
    end else begin : g_next
      assign xi = sx[i-1];
      assign yi = sy[i-1];
      assign ai = sa[i-1];
      assign di = sd[i-1];
      assign vi = sv[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i] <= 1'b0;
      end else begin
        sv[i] <= vi;
      end
      sd[i] <= di;
      if (di) begin
        sx[i] <= xi;
        sy[i] <= yi;
        sa[i] <= ai;
      end else if (!yi[XY_W-1]) begin
        sx[i] <= xi + (yi >>> i);
        sy[i] <= yi - (xi >>> i);
        sa[i] <= ai + ATAN_TURNS[i];
      end else begin
        sx[i] <= xi - (yi >>> i);
        sy[i] <= yi + (xi >>> i);
        sa[i] <= ai - ATAN_TURNS[i];
      end
    end
  end

  assign out_valid = sv[CORDIC_STEPS-1];
  assign ang = sa[CORDIC_STEPS-1];

endmodule

// ===== src/rsbl_div.sv =====
module rsbl_div #(
  parameter int QB = 7
) (
  input  logic             clk,
  input  logic [19:0]      ring_pitch,
  input  logic [27:0]      mag,
  input  logic             neg,
  input  logic             bad,
  output logic [QB-1:0]    quot,
  output logic             ovf,
  output logic             out_neg,
  output logic             out_bad
);
  import rsbl_pkg::*;

  localparam int CW = MAG_W + QB;

  logic [MAG_W-1:0] rem [CORDIC_STEPS];
  logic [QB-1:0] qs [CORDIC_STEPS];
  logic os [CORDIC_STEPS];
  logic ns [CORDIC_STEPS];
  logic bs [CORDIC_STEPS];
  logic [CW-1:0] dext;

  assign dext = CW'({ring_pitch, 1'b0});

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    if (i == 0) begin : g_ovf
      always_ff @(posedge clk) begin
        rem[i] <= mag;
        qs[i] <= '0;
        os[i] <= (CW'(mag) >= (dext << QB));
        ns[i] <= neg;
        bs[i] <= bad;
      end
    end else if (i <= QB) begin : g_bit
      localparam int K = QB - i;
      logic take;
      logic [QB-1:0] q_next;
      assign take = (CW'(rem[i-1]) >= (dext << K));
      always_comb begin
        q_next = qs[i-1];
        q_next[K] = take;
      end
      always_ff @(posedge clk) begin
        rem[i] <= take ? MAG_W'(CW'(rem[i-1]) - (dext << K)) : rem[i-1];
        qs[i] <= q_next;
        os[i] <= os[i-1];
        ns[i] <= ns[i-1];
        bs[i] <= bs[i-1];
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        rem[i] <= rem[i-1];
        qs[i] <= qs[i-1];
        os[i] <= os[i-1];
        ns[i] <= ns[i-1];
        bs[i] <= bs[i-1];
      end
    end
  end

  assign quot = qs[CORDIC_STEPS-1];
  assign ovf = os[CORDIC_STEPS-1];
  assign out_neg = ns[CORDIC_STEPS-1];
  assign out_bad = bs[CORDIC_STEPS-1];

endmodule

// ===== src/rsbl_back.sv =====
module rsbl_back #(
  parameter int MAX_RINGS = 64,
  parameter int ANGLE_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  rsbl_pkg::task_t item,
  input  rsbl_pkg::cfg_t  cfg,
  output logic            done,
  output logic [11:0]     block_id,
  output logic            out_of_range
);
  import rsbl_pkg::*;

  localparam int QB = $clog2(MAX_RINGS + 1);
  localparam int TW = ANGLE_BITS + 8;
  localparam int IW = QB + 9;

  logic c_valid;
  logic [ANG_W-1:0] c_ang;
  logic [QB-1:0] d_quot;
  logic d_ovf;
  logic d_neg;
  logic d_bad;

  rsbl_cordic u_cordic (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .item(item),
    .out_valid(c_valid),
    .ang(c_ang)
  );

  rsbl_div #(.QB(QB)) u_div (
    .clk(clk),
    .ring_pitch(cfg.ring_pitch),
    .mag(item.mag),
    .neg(item.neg),
    .bad(item.bad),
    .quot(d_quot),
    .ovf(d_ovf),
    .out_neg(d_neg),
    .out_bad(d_bad)
  );

  logic [ANG_W:0] rnd;
  logic [ANGLE_BITS-1:0] phi;
  logic a_valid;
  logic a_bad;
  logic [QB-1:0] a_ring;
  logic [TW-1:0] a_twice;

  assign rnd = {1'b0, c_ang} + ((ANG_W+1)'(1) << (31 - ANGLE_BITS));
  assign phi = rnd[ANG_W-1:ANG_W-ANGLE_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= c_valid;
    end
    a_bad <= d_bad || (d_neg && ((d_quot != '0) || d_ovf)) || (!d_neg && d_ovf);
    a_ring <= d_neg ? '0 : d_quot;
    a_twice <= (TW'(cfg.blocks_per_ring) * TW'(phi)) << 1;
  end

  logic [TW-1:0] turn;
  logic [TW-1:0] lim;
  logic [TW-1:0] bsum;
  logic [7:0] block;
  logic [IW-1:0] index;
  logic [13:0] total;
  logic bad_b;

  assign turn = TW'(1) << ANGLE_BITS;
  assign lim = (TW'({cfg.blocks_per_ring, 1'b0}) - TW'(1)) << ANGLE_BITS;
  assign bsum = a_twice + turn;
  assign block = ((a_twice > turn) && (a_twice < lim)) ? 8'(bsum >> (ANGLE_BITS + 1)) : 8'd0;
  assign index = IW'(IW'(a_ring) * IW'(cfg.blocks_per_ring)) + IW'(block);
  assign total = 14'(cfg.ring_count) * 14'(cfg.blocks_per_ring);
  assign bad_b = a_bad || (index >= IW'(total)) || (index > IW'(INDEX_LIMIT));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a_valid;
    end
    block_id <= bad_b ? 12'd0 : index[IDX_W-1:0];
    out_of_range <= bad_b;
  end

endmodule

// ===== src/ring_scanner_block_locate_unit.sv =====
// Ring scanner block locator.
// A request carries one point (x_coord, y_coord, z_coord, signed Q15.8) and is
// taken at a rising edge where start is high and busy is low. The block maps
// the point to a detector block index, ring times blocks_per_ring plus block,
// with out_of_range set and block_id zero when the point lies in no block.
// Each result appears for exactly one cycle with done high; the receiver
// cannot hold results off, and none is needed since the back end never stops.
// A request passes through the queue, the 28-stage CORDIC pipeline and the
// rounding and index stages; the ring divider runs alongside the CORDIC in
// the same number of stages. One request is accepted every cycle, so busy
// stays low in normal use. Registers are to be written through cfg_write,
// cfg_index and cfg_data only while no request is in flight; the block does
// not enforce this. Indexes beyond the three registers are ignored.
// A synchronous reset restores ring_pitch 8192, a ring count of 4 and
// blocks_per_ring 32 and drops every request in flight.
module ring_scanner_block_locate_unit #(
  parameter int MAX_RINGS = 64,
  parameter int MAX_BLOCKS_PER_RING = 64,
  parameter int ANGLE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic signed [23:0] x_coord,
  input  logic signed [23:0] y_coord,
  input  logic signed [23:0] z_coord,
  output logic              done,
  output logic [11:0]       block_id,
  output logic              out_of_range,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [19:0]       cfg_data
);
  import rsbl_pkg::*;

  cfg_t cfg;
  task_t f_item;
  task_t q_item;
  logic q_valid;
  logic q_full;
  logic accept;

  assign busy = q_full;
  assign accept = start && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ring_pitch <= RESET_PITCH;
      cfg.ring_count <= RESET_RINGS;
      cfg.blocks_per_ring <= RESET_BLOCKS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RING_PITCH: cfg.ring_pitch <= cfg_data;
        REG_RING_COUNT: cfg.ring_count <= cfg_data[CNT_W-1:0];
        REG_BLOCKS_PER_RING: cfg.blocks_per_ring <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rsbl_front #(
    .MAX_RINGS(MAX_RINGS),
    .MAX_BLOCKS_PER_RING(MAX_BLOCKS_PER_RING)
  ) u_front (
    .x_coord(x_coord),
    .y_coord(y_coord),
    .z_coord(z_coord),
    .cfg(cfg),
    .item(f_item)
  );

  rsbl_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(accept),
    .push_item(f_item),
    .pop(q_valid),
    .out_valid(q_valid),
    .out_item(q_item),
    .full(q_full)
  );

  rsbl_back #(
    .MAX_RINGS(MAX_RINGS),
    .ANGLE_BITS(ANGLE_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .in_valid(q_valid),
    .item(q_item),
    .cfg(cfg),
    .done(done),
    .block_id(block_id),
    .out_of_range(out_of_range)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rsbl_pkg::*;

  localparam int ANGLE_BITS = 16;
  localparam int LATENCY = 31;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [11:0] block_id;
    logic out_of_range;
  } locate_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [23:0] x_coord = '0;
  logic signed [23:0] y_coord = '0;
  logic signed [23:0] z_coord = '0;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [19:0] cfg_data = '0;
  logic busy, done, out_of_range;
  logic [11:0] block_id;

  logic [19:0] pitch_q;
  logic [6:0] rings_q;
  logic [6:0] blocks_q;
  locate_t locate_queue[$];
  int fail_count = 0;
  int result_count = 0;
  int request_count = 0;
  int idle_cycles = 0;
  int idle_pct = 19;

  ring_scanner_block_locate_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord),
    .done(done), .block_id(block_id), .out_of_range(out_of_range),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic longint floor_shift(longint v, int s);
    if (v < 0) return -1 - ((-1 - v) >>> s);
    return v >>> s;
  endfunction

  function automatic logic [31:0] azimuth(longint x, longint y);
    logic [31:0] ang;
    longint xs, ys;
    ang = TURN_ZERO;
    if (y == 0) return (x < 0) ? TURN_HALF : TURN_ZERO;
    if (x == 0) return (y > 0) ? TURN_QUARTER : TURN_3QUARTER;
    x = x * 256;
    y = y * 256;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = TURN_HALF;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        ang = ang + ATAN_TURNS[i];
      end else begin
        x = x - ys;
        y = y + xs;
        ang = ang - ATAN_TURNS[i];
      end
    end
    return ang;
  endfunction

  function automatic locate_t locate_block(longint x, longint y, longint z);
    locate_t r;
    longint pitch, nr, nb, ring, idx, blk;
    longint unsigned phi, dbl, t;
    pitch = pitch_q;
    nr = rings_q;
    nb = blocks_q;
    t = 64'd1 << ANGLE_BITS;
    r.block_id = '0;
    r.out_of_range = 1'b1;
    if (pitch == 0 || nb == 0 || nr > 64 || nb > 64) return r;
    ring = (2 * z + pitch * nr) / (2 * pitch);
    phi = azimuth(x, y);
    phi = ((phi + (64'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS)) & (t - 1);
    dbl = 2 * nb * phi;
    blk = 0;
    if (dbl > t && dbl < (2 * nb - 1) * t) blk = (dbl + t) / (2 * t);
    idx = ring * nb + blk;
    if (!(ring < 0 || idx >= nr * nb || idx > 4095)) begin
      r.block_id = idx[11:0];
      r.out_of_range = 1'b0;
    end
    return r;
  endfunction

  task automatic send_point(logic [23:0] x, logic [23:0] y, logic [23:0] z);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    x_coord <= x;
    y_coord <= y;
    z_coord <= z;
    locate_queue.insert(locate_queue.size(),
                        locate_block($signed(x), $signed(y), $signed(z)));
    @(posedge clk);
    while (busy) @(posedge clk);
    request_count++;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [19:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_RING_PITCH: pitch_q = val;
      REG_RING_COUNT: rings_q = val[6:0];
      REG_BLOCKS_PER_RING: blocks_q = val[6:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (locate_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_geometry(logic [19:0] p, logic [6:0] nr, logic [6:0] nb);
    drain();
    write_reg(REG_RING_PITCH, p);
    write_reg(REG_RING_COUNT, {13'd0, nr});
    write_reg(REG_BLOCKS_PER_RING, {13'd0, nb});
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(4095) - 2048);
      2: return ($urandom_range(1)) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($urandom_range(65535) - 32768);
    endcase
  endfunction

  task automatic test_directed;
    send_point(0, 0, 0);
    send_point(24'h7FFFFF, 0, 0);
    send_point(24'h800000, 0, 0);
    send_point(0, 24'h7FFFFF, 0);
    send_point(0, 24'h800000, 0);
    send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_point(24'h800000, 24'h800000, 24'h800000);
    send_point(256, 24'(-1), 0);
    send_point(24'(-256), 1, 0);
    send_point(1000, 50, 24'(-16384));
    send_point(1000, 50, 24'(-16385));
    send_point(1000, 50, 24'(-16383));
    send_point(1000, 50, 16383);
    send_point(1000, 50, 16384);
    send_point(24'(-1000), 24'(-50), 100);
    send_point(24'h555555, 24'hAAAAAA, 24'h0F0F0F);
  endtask

  task automatic test_register_extremes;
    set_geometry(20'd1, 7'd1, 7'd1);
    repeat (4) send_point(rand_coord(), rand_coord(), 24'($urandom_range(3) - 1));
    set_geometry(20'hFFFFF, 7'd64, 7'd64);
    repeat (6) send_point(rand_coord(), rand_coord(), rand_coord());
    set_geometry(20'd0, 7'd4, 7'd32);
    repeat (3) send_point(rand_coord(), rand_coord(), rand_coord());
    set_geometry(20'd256, 7'd0, 7'd8);
    repeat (3) send_point(rand_coord(), rand_coord(), 0);
    set_geometry(20'd256, 7'd8, 7'd0);
    repeat (3) send_point(rand_coord(), rand_coord(), 0);
    set_geometry(20'd256, 7'd127, 7'd65);
    repeat (3) send_point(rand_coord(), rand_coord(), 0);
    drain();
    write_reg(reg_idx_t'(2'd3), 20'hFFFFF);
    repeat (3) send_point(rand_coord(), rand_coord(), 0);
  endtask

  task automatic test_random;
    for (int n = 0; n < 650; n++) begin
      if (n % 80 == 0)
        set_geometry(20'(($urandom_range(3) == 0) ? $urandom : $urandom_range(16384, 1)),
                     7'($urandom_range(64, 1)), 7'($urandom_range(64, 1)));
      idle_pct = (n >= 200 && n < 320) ? 0 : 19;
      send_point(rand_coord(), rand_coord(),
                 ($urandom_range(1)) ? rand_coord()
                   : 24'(pitch_q * (rings_q / 2 + 1) - $urandom_range(3 * pitch_q)));
    end
  endtask

  always @(posedge clk) begin
    locate_t e;
    if (!rst && done) begin
      result_count++;
      if (locate_queue.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        e = locate_queue.pop_front();
        if (block_id !== e.block_id) begin
          $error("block_id expected %0d actual %0d", e.block_id, block_id);
          fail_count++;
        end
        if (out_of_range !== e.out_of_range) begin
          $error("out_of_range expected %0d actual %0d", e.out_of_range, out_of_range);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    pitch_q = RESET_PITCH;
    rings_q = RESET_RINGS;
    blocks_q = RESET_BLOCKS;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random();
    drain();
    $display("Sent %0d points, checked %0d results over several geometries.",
             request_count, result_count);
    if (fail_count == 0 && locate_queue.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

// ===== ring_scanner_block_locate_unit.f =====
src/rsbl_pkg.sv
src/rsbl_front.sv
src/rsbl_queue.sv
src/rsbl_cordic.sv
src/rsbl_div.sv
src/rsbl_back.sv
src/ring_scanner_block_locate_unit.sv
tb/tb.sv
